// ===== rtl/core/lbm_cm_pkg.sv =====
// Shared types, constants and a helper function of the D2Q9 cell moment pipeline.
package lbm_cm_pkg;

    // Default fraction width of the Q format and reset value of the rest density.
    localparam int FRAC_BITS_DEF = 24;
    localparam logic [31:0] REST_DENSITY_RST = 32'd1677722;

    // Operand widths: sums of three distributions and of all nine.
    localparam int MAG_W = 34;
    localparam int DEN_W = 36;
    localparam int QW    = 32;

    // Latencies of the divider and square root units in register stages.
    localparam int DIV_LAT = QW + 1;
    localparam int SQ_LAT  = QW + 1;

    // Pressure is worked out by long division by three, one byte per stage.
    localparam int P3_STEPS = 5;
    localparam int P_W      = 8 * P3_STEPS;

    // Velocity saturation limits.
    localparam logic [31:0] VEL_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VEL_NEG_MAX = 32'h8000_0000;

    // Sideband that travels alongside the velocity dividers.
    typedef struct packed {
        logic             neg_x;
        logic             neg_y;
        logic             blk;
        logic             zero;
        logic [P_W-1:0]   p_num;
        logic [P_W-1:0]   p_quo;
        logic [1:0]       p_rem;
    } t_dv_side;

    // Sideband that travels alongside the square root unit.
    typedef struct packed {
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] pressure;
        logic        zero;
    } t_sq_side;

    // One byte of long division by three: returns the new remainder and eight quotient bits.
    function automatic logic [9:0] div3_8(input logic [1:0] rem, input logic [7:0] bits);
        logic [2:0] r;
        logic [7:0] q;
        r = {1'b0, rem};
        for (int b = 7; b >= 0; b--) begin
            r = {r[1:0], bits[b]};
            if (r >= 3'd3) begin
                r    = r - 3'd3;
                q[b] = 1'b1;
            end else begin
                q[b] = 1'b0;
            end
        end
        return {r[1:0], q};
    endfunction

endpackage

// ===== rtl/core/lbm_cm_div.sv =====
// Pipelined restoring divider giving a rounded 32-bit fixed point quotient per cycle while enabled.
module lbm_cm_div #(
    parameter int FRAC_BITS = lbm_cm_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [lbm_cm_pkg::MAG_W-1:0]  i_mag,
    input  logic [lbm_cm_pkg::DEN_W-1:0]  i_den,
    output logic [lbm_cm_pkg::QW-1:0]     o_quot,
    output logic                          o_ovf
);
    import lbm_cm_pkg::*;

    localparam int NW = MAG_W + FRAC_BITS + 1;
    localparam int CW = (NW > DEN_W + QW) ? NW : DEN_W + QW;

    logic [NW-1:0]    r_rem [0:QW-1];
    logic [DEN_W-1:0] r_den [0:QW-1];
    logic [QW-1:0]    r_q   [0:QW];
    logic             r_ovf [0:QW];
    logic [NW-1:0]    w_num;

    // Scaled numerator with half the divisor added for round to nearest.
    assign w_num = (NW'(i_mag) << FRAC_BITS) + NW'(i_den >> 1);

    // First stage: numerator and overflow check against a 32-bit quotient.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= CW'(w_num >> QW) >= CW'(i_den);
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar s = 1; s <= QW; s++) begin : g_step
        logic [CW-1:0] w_trial;
        logic          w_ge;

        assign w_trial = CW'(r_den[s-1]) << (QW - s);
        assign w_ge    = CW'(r_rem[s-1]) >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s]   <= {r_q[s-1][QW-2:0], w_ge};
                r_ovf[s] <= r_ovf[s-1];
            end
        end

        if (s < QW) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= w_ge ? NW'(CW'(r_rem[s-1]) - w_trial) : r_rem[s-1];
                    r_den[s] <= r_den[s-1];
                end
            end
        end
    end

    assign o_quot = r_q[QW];
    assign o_ovf  = r_ovf[QW];

endmodule

// ===== rtl/core/lbm_cm_sqrt.sv =====
// Pipelined integer square root of a 64-bit value, rounded to nearest and saturated.
module lbm_cm_sqrt (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [2*lbm_cm_pkg::QW-1:0] i_val,
    output logic [lbm_cm_pkg::QW-1:0] o_root
);
    import lbm_cm_pkg::*;

    localparam int VW = 2 * QW;

    logic [VW-1:0] r_rem  [0:QW-1];
    logic [QW-1:0] r_root [0:QW-1];
    logic [VW-1:0] w_rem_in  [0:QW-1];
    logic [QW-1:0] w_root_in [0:QW-1];
    logic [QW-1:0] r_out;

    // One root bit per stage; the remainder holds value minus root squared.
    for (genvar s = 0; s < QW; s++) begin : g_step
        localparam int BI = QW - 1 - s;
        logic [VW:0] w_trial;
        logic        w_ge;

        if (s == 0) begin : g_first
            assign w_rem_in[s]  = i_val;
            assign w_root_in[s] = '0;
        end else begin : g_next
            assign w_rem_in[s]  = r_rem[s-1];
            assign w_root_in[s] = r_root[s-1];
        end

        assign w_trial = ((VW+1)'(w_root_in[s]) << (BI + 1)) + ((VW+1)'(1) << (2 * BI));
        assign w_ge    = (VW+1)'(w_rem_in[s]) >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_ge ? VW'((VW+1)'(w_rem_in[s]) - w_trial) : w_rem_in[s];
                r_root[s] <= w_ge ? (w_root_in[s] | (QW'(1) << BI)) : w_root_in[s];
            end
        end
    end

    // Round up when the remainder exceeds the root, saturating at full scale.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_rem[QW-1] > VW'(r_root[QW-1]) && r_root[QW-1] != '1) begin
                r_out <= r_root[QW-1] + QW'(1);
            end else if (r_rem[QW-1] > VW'(r_root[QW-1])) begin
                r_out <= '1;
            end else begin
                r_out <= r_root[QW-1];
            end
        end
    end

    assign o_root = r_out;

endmodule

// ===== rtl/core/lbm_d2q9_cell_moments.sv =====
// D2Q9 lattice cell moments: velocity, speed and pressure from nine distributions.
// Stages from input transaction to result: sums, dividers, clamp and squares, then the
// square root; the output register is the last of those stages.
// Throughput: one cell per clock; the whole pipeline holds while a result is not taken.
// Reset: synchronous, active low; clears all valid bits and loads rest_density with
// its default of about 0.1. No clearing pass is needed.
module lbm_d2q9_cell_moments #(
    parameter int FRAC_BITS = lbm_cm_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_dist_rest,
    input  logic [31:0]        i_dist_east,
    input  logic [31:0]        i_dist_west,
    input  logic [31:0]        i_dist_north,
    input  logic [31:0]        i_dist_south,
    input  logic [31:0]        i_dist_north_east,
    input  logic [31:0]        i_dist_north_west,
    input  logic [31:0]        i_dist_south_east,
    input  logic [31:0]        i_dist_south_west,
    input  logic               i_blocked,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_vel_x,
    output logic signed [31:0] o_vel_y,
    output logic [31:0]        o_speed,
    output logic [31:0]        o_pressure,
    output logic               o_zero_density,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);
    import lbm_cm_pkg::*;

    localparam int ST_C = 2 + DIV_LAT;
    localparam int L    = ST_C + 3 + SQ_LAT;

    logic             en;
    logic [L-1:0]     r_vld;
    logic [31:0]      r_rest_density;

    logic [MAG_W-1:0] r_a_posx, r_a_negx, r_a_posy, r_a_negy, r_a_nsr;
    logic             r_a_blk;

    logic [DEN_W-1:0] r_b_den;
    logic [MAG_W-1:0] r_b_mx, r_b_my;
    t_dv_side         r_b_side;
    logic [DEN_W-1:0] w_den;

    t_dv_side         r_ds [0:DIV_LAT-1];
    logic [QW-1:0]    w_qx, w_qy;
    logic             w_ovfx, w_ovfy;

    logic [31:0]      r_c_mx, r_c_my;
    t_sq_side         r_c_side;
    logic [63:0]      w_satx, w_saty;

    logic [63:0]      r_d_sqx, r_d_sqy;
    t_sq_side         r_d_side;
    logic [63:0]      r_e_sum;
    t_sq_side         r_e_side;
    t_sq_side         r_ss [0:SQ_LAT-1];

    // Saturate a quotient magnitude to the signed range; returns magnitude and pattern.
    function automatic logic [63:0] sat_vel(input logic neg, input logic ovf,
                                            input logic [31:0] q);
        logic [31:0] m;
        if (neg) begin
            m = (ovf || q > VEL_NEG_MAX) ? VEL_NEG_MAX : q;
            return {m, 32'd0 - m};
        end
        m = (ovf || q > VEL_POS_MAX) ? VEL_POS_MAX : q;
        return {m, m};
    endfunction

    // Global advance: every stage moves when the output register is free or taken.
    // Neither channel takes a transaction while reset is held.
    assign en          = !r_vld[L-1] || i_ready;
    assign o_ready     = en && i_rst_n;
    assign o_valid     = r_vld[L-1];
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld          <= '0;
            r_rest_density <= REST_DENSITY_RST;
        end else begin
            if (en) begin
                r_vld <= {r_vld[L-2:0], i_valid};
            end
            if (i_cfg_valid) begin
                r_rest_density <= i_cfg_data;
            end
        end
    end

    // Stage A: directional partial sums.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_posx <= MAG_W'(i_dist_east) + MAG_W'(i_dist_north_east)
                      + MAG_W'(i_dist_south_east);
            r_a_negx <= MAG_W'(i_dist_west) + MAG_W'(i_dist_north_west)
                      + MAG_W'(i_dist_south_west);
            r_a_posy <= MAG_W'(i_dist_north) + MAG_W'(i_dist_north_east)
                      + MAG_W'(i_dist_north_west);
            r_a_negy <= MAG_W'(i_dist_south) + MAG_W'(i_dist_south_east)
                      + MAG_W'(i_dist_south_west);
            r_a_nsr  <= MAG_W'(i_dist_north) + MAG_W'(i_dist_south) + MAG_W'(i_dist_rest);
            r_a_blk  <= i_blocked;
        end
    end

    // Stage B: density, momentum magnitudes and signs, pressure dividend.
    assign w_den = DEN_W'(r_a_posx) + DEN_W'(r_a_negx) + DEN_W'(r_a_nsr);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_den         <= w_den;
            r_b_mx          <= (r_a_negx > r_a_posx) ? r_a_negx - r_a_posx : r_a_posx - r_a_negx;
            r_b_my          <= (r_a_negy > r_a_posy) ? r_a_negy - r_a_posy : r_a_posy - r_a_negy;
            r_b_side.neg_x  <= r_a_negx > r_a_posx;
            r_b_side.neg_y  <= r_a_negy > r_a_posy;
            r_b_side.blk    <= r_a_blk;
            r_b_side.zero   <= !r_a_blk && w_den == '0;
            r_b_side.p_num  <= r_a_blk ? P_W'(r_rest_density) + P_W'(1)
                                       : P_W'(w_den) + P_W'(1);
            r_b_side.p_quo  <= '0;
            r_b_side.p_rem  <= '0;
        end
    end

    // Velocity dividers.
    lbm_cm_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_mag  (r_b_mx),
        .i_den  (r_b_den),
        .o_quot (w_qx),
        .o_ovf  (w_ovfx)
    );

    lbm_cm_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_mag  (r_b_my),
        .i_den  (r_b_den),
        .o_quot (w_qy),
        .o_ovf  (w_ovfy)
    );

    // Sideband alongside the dividers; the first stages also divide the pressure by three.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ds[0] <= r_b_side;
        end
    end

    for (genvar j = 1; j < DIV_LAT; j++) begin : g_ds
        t_dv_side w_nxt;

        if (j <= P3_STEPS) begin : g_div3
            logic [9:0] w_d3;
            always_comb begin
                w_d3  = div3_8(r_ds[j-1].p_rem, r_ds[j-1].p_num[8*(P3_STEPS-j) +: 8]);
                w_nxt = r_ds[j-1];
                w_nxt.p_rem = w_d3[9:8];
                w_nxt.p_quo[8*(P3_STEPS-j) +: 8] = w_d3[7:0];
            end
        end else begin : g_pass
            assign w_nxt = r_ds[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ds[j] <= w_nxt;
            end
        end
    end

    // Stage C: saturation, special cells and pressure.
    assign w_satx = sat_vel(r_ds[DIV_LAT-1].neg_x, w_ovfx, w_qx);
    assign w_saty = sat_vel(r_ds[DIV_LAT-1].neg_y, w_ovfy, w_qy);

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_ds[DIV_LAT-1].blk || r_ds[DIV_LAT-1].zero) begin
                r_c_mx         <= '0;
                r_c_my         <= '0;
                r_c_side.vel_x <= '0;
                r_c_side.vel_y <= '0;
            end else begin
                r_c_mx         <= w_satx[63:32];
                r_c_my         <= w_saty[63:32];
                r_c_side.vel_x <= w_satx[31:0];
                r_c_side.vel_y <= w_saty[31:0];
            end
            if (r_ds[DIV_LAT-1].zero) begin
                r_c_side.pressure <= '0;
            end else if (r_ds[DIV_LAT-1].p_quo[P_W-1:32] != '0) begin
                r_c_side.pressure <= '1;
            end else begin
                r_c_side.pressure <= r_ds[DIV_LAT-1].p_quo[31:0];
            end
            r_c_side.zero <= r_ds[DIV_LAT-1].zero;
        end
    end

    // Stages D and E: squares of the magnitudes, then their sum.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_sqx  <= 64'(r_c_mx) * 64'(r_c_mx);
            r_d_sqy  <= 64'(r_c_my) * 64'(r_c_my);
            r_d_side <= r_c_side;
            r_e_sum  <= r_d_sqx + r_d_sqy;
            r_e_side <= r_d_side;
        end
    end

    // Speed from the square root unit; results wait alongside it.
    lbm_cm_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (r_e_sum),
        .o_root (o_speed)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ss[0] <= r_e_side;
        end
    end

    for (genvar k = 1; k < SQ_LAT; k++) begin : g_ss
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ss[k] <= r_ss[k-1];
            end
        end
    end

    assign o_vel_x        = $signed(r_ss[SQ_LAT-1].vel_x);
    assign o_vel_y        = $signed(r_ss[SQ_LAT-1].vel_y);
    assign o_pressure     = r_ss[SQ_LAT-1].pressure;
    assign o_zero_density = r_ss[SQ_LAT-1].zero;

    // A zero density cell reports all values as zero.
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_density |->
            o_vel_x == 0 && o_vel_y == 0 && o_speed == 0 && o_pressure == 0)
        else $error("zero density result carries nonzero values");

    // The speed is never below a nonnegative x velocity.
    a_speed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_vel_x[31] |-> o_speed >= $unsigned(o_vel_x))
        else $error("speed below x velocity");

    // A held pipeline keeps its occupancy.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline occupancy changed during a hold");

endmodule
